@@ rtl/lpc_pkg.sv @@
// Shared types and constants for the LiDAR point covariance block.
// No dependencies; imported by every module of the block.
package lpc_pkg;

  // Payload of one input word and one result word
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } lpc_in_t;

  typedef struct packed {
    logic signed [63:0] cov_xx;
    logic signed [63:0] cov_xy;
    logic signed [63:0] cov_xz;
    logic signed [63:0] cov_yy;
    logic signed [63:0] cov_yz;
    logic signed [63:0] cov_zz;
    logic               saturated;
  } lpc_out_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 21;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_ERR = 1'b0,
    REG_BEAM_ERR  = 1'b1
  } lpc_reg_e;

  localparam logic [15:0] RANGE_ERR_RST = 16'd1311;
  localparam logic [20:0] BEAM_ERR_RST  = 21'd3277;
  localparam logic [20:0] BEAM_MAX      = 21'd1966080;

  // Degrees to radians, Q.32, rounded
  localparam longint unsigned DEG2RAD_Q32 =
    ((64'd17453293 << 32) + 64'd500000000) / 64'd1000000000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Coefficients handed from the coefficient unit to the datapath
  typedef struct packed {
    logic        busy;
    logic [31:0] s2;
    logic [31:0] e2;
  } lpc_coef_t;

  // Word carried between front and back through the queue
  typedef struct packed {
    logic [5:0][61:0] num;   // u_i*u_j of the normalized magnitudes
    logic [31:0]      den;   // upper word of the normalized sum of squares
    logic [5:0][63:0] msum;  // multiplicand of the angular term
    logic [2:0]       neg;   // coordinate signs
  } lpc_item_t;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  // Entry order: xx, xy, xz, yy, yz, zz
  localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h8000_0000_0000_0000;

  // Horner steps of the sine series divide by 72, 42, 20 and 6.
  // Each is a reciprocal multiply, (v * m) >> sh, exact for any 32-bit v.
  function automatic logic [32:0] horner_recip(logic [1:0] idx);
    logic [32:0] m;
    case (idx)
      2'd0:    m = 33'h0_E38E_38E4;
      2'd1:    m = 33'h1_8618_6187;
      2'd2:    m = 33'h0_CCCC_CCCD;
      default: m = 33'h0_AAAA_AAAB;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(logic [1:0] idx);
    logic [5:0] sh;
    case (idx)
      2'd0:    sh = 6'd38;
      2'd1:    sh = 6'd38;
      2'd2:    sh = 6'd36;
      default: sh = 6'd34;
    endcase
    return sh;
  endfunction

endpackage

@@ rtl/lpc_coef.sv @@
// Configuration registers and the coefficient unit (sin^2 of beam error, range error^2).
// Depends on lpc_pkg. Sine terms share one sequenced multiplier; restarts on every register write.
module lpc_coef (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lpc_pkg::lpc_coef_t            coef_o
);
  import lpc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_XMUL = 7'b0000010,
    S_X2   = 7'b0000100,
    S_TMUL = 7'b0001000,
    S_TDIV = 7'b0010000,
    S_SMUL = 7'b0100000,
    S_S2   = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] range_q;
  logic [20:0] beam_q, beam_c;
  logic [31:0] x_q, x2_q, s_q, s2_q, e2_q;
  logic [32:0] t_q;
  logic [31:0] dvd_q;  // Horner product waiting for its constant divide
  logic [31:0] quo;
  logic [1:0]  idx_q;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  assign beam_c = (beam_q > BEAM_MAX) ? BEAM_MAX : beam_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_XMUL: begin
        mul_a = {12'd0, beam_c};
        mul_b = DEG2RAD_Q32[32:0];
      end
      S_X2: begin
        mul_a = {1'b0, x_q};
        mul_b = {1'b0, x_q};
      end
      S_TMUL: begin
        mul_a = {1'b0, x2_q};
        mul_b = t_q;
      end
      S_TDIV: begin
        mul_a = {1'b0, dvd_q};
        mul_b = horner_recip(idx_q);
      end
      S_SMUL: begin
        mul_a = {1'b0, x_q};
        mul_b = t_q;
      end
      S_S2: begin
        mul_a = {1'b0, s_q};
        mul_b = {1'b0, s_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Constant divide by reciprocal multiplication
  assign quo = 32'(prod >> horner_shift(idx_q));

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: state_d = S_IDLE;
      S_XMUL: state_d = S_X2;
      S_X2:   state_d = S_TMUL;
      S_TMUL: state_d = S_TDIV;
      S_TDIV: state_d = (idx_q == 2'd3) ? S_SMUL : S_TMUL;
      S_SMUL: state_d = S_S2;
      S_S2:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = S_XMUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_XMUL;
      range_q <= RANGE_ERR_RST;
      beam_q  <= BEAM_ERR_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (lpc_reg_e'(cfg_idx_i))
          REG_RANGE_ERR: range_q <= cfg_wdata_i[15:0];
          REG_BEAM_ERR:  beam_q  <= cfg_wdata_i[20:0];
          default:       range_q <= range_q;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_XMUL: begin
        x_q   <= prod[47:16];
        t_q   <= ONE_Q32;
        idx_q <= 2'd0;
      end
      S_X2:   x2_q  <= prod[63:32];
      S_TMUL: dvd_q <= prod[63:32];
      S_TDIV: begin
        t_q   <= ONE_Q32 - {1'b0, quo};
        idx_q <= idx_q + 2'd1;
      end
      S_SMUL: s_q <= prod[63:32];
      S_S2: begin
        s2_q <= prod[63:32];
        e2_q <= range_q * range_q;
      end
      default: x_q <= x_q;
    endcase
  end

  assign coef_o.busy = (state_q != S_IDLE);
  assign coef_o.s2   = s2_q;
  assign coef_o.e2   = e2_q;

  // A write always restarts the coefficient sequence
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == S_XMUL) else $error("coef unit not restarted");

endmodule

@@ rtl/lpc_front.sv @@
// Front of the covariance datapath: magnitudes, squares, normalization, numerators.
// Depends on lpc_pkg. Five register stages feeding the queue; admits on queue credit and an idle coefficient unit.
module lpc_front #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  lpc_pkg::lpc_in_t                point_i,
  input  logic                            coef_busy_i,
  input  logic [lpc_pkg::FIFO_CW-1:0]     fifo_cnt_i,
  output logic                            ready_o,
  output logic                            item_valid_o,
  output lpc_pkg::lpc_item_t              item_o
);
  import lpc_pkg::*;

  localparam longint unsigned ZEPS_RAW = ((64'd1 << COORD_FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [31:0] ZEPS = (ZEPS_RAW == 0) ? 32'd1 : 32'(ZEPS_RAW);

  function automatic logic [4:0] lead_zeros(logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else      n = n + 5'd1;
      end
    end
    return n;
  endfunction

  logic [4:0] v_q;
  logic [2:0] pending;
  logic [FIFO_CW-1:0] total;

  // Stage 1: magnitudes and signs
  logic [2:0][31:0] raw;
  logic [2:0][31:0] mag1_d, mag1_q;
  logic [2:0]       neg1_d, neg1_q;
  // Stage 2: products and the largest magnitude
  logic [2:0][31:0] mag2_q;
  logic [2:0]       neg2_q;
  logic [2:0][63:0] sq2_q, pm2_q;
  logic [31:0]      max2_d, max2_q;
  // Stage 3: shift amount and angular-term multiplicands
  logic [2:0][31:0] mag3_q;
  logic [2:0]       neg3_q;
  logic [5:0][63:0] ms3_q;
  logic             shr3_q;
  logic [4:0]       shl3_q;
  // Stage 4: normalized magnitudes
  logic [2:0][31:0] u4_q;
  logic [2:0]       neg4_q;
  logic [5:0][63:0] ms4_q;
  // Stage 5: numerators
  logic [5:0][61:0] n5_q;
  logic [2:0]       neg5_q;
  logic [5:0][63:0] ms5_q;
  logic [63:0]      r2n;

  // Credit: everything in the front plus the queue must fit the queue
  assign pending = 3'(v_q[0]) + 3'(v_q[1]) + 3'(v_q[2]) + 3'(v_q[3]) + 3'(v_q[4]);
  assign total   = FIFO_CW'(pending) + fifo_cnt_i;
  assign ready_o = !coef_busy_i && (total < FIFO_CW'(FIFO_DEPTH));

  assign raw = {point_i.point_z, point_i.point_y, point_i.point_x};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_d[i] = raw[i][31];
      mag1_d[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
    // Zero z is replaced by a small positive height
    if (mag1_d[2] == '0) begin
      mag1_d[2] = ZEPS;
      neg1_d[2] = 1'b0;
    end
  end

  assign max2_d = (mag1_q[0] >= mag1_q[1]) ?
                  ((mag1_q[0] >= mag1_q[2]) ? mag1_q[0] : mag1_q[2]) :
                  ((mag1_q[1] >= mag1_q[2]) ? mag1_q[1] : mag1_q[2]);

  assign r2n = 64'(n5_q[0]) + 64'(n5_q[3]) + 64'(n5_q[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q <= mag1_d;
    neg1_q <= neg1_d;

    mag2_q <= mag1_q;
    neg2_q <= neg1_q;
    max2_q <= max2_d;
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= mag1_q[i] * mag1_q[i];
    end
    pm2_q[0] <= mag1_q[0] * mag1_q[1];
    pm2_q[1] <= mag1_q[0] * mag1_q[2];
    pm2_q[2] <= mag1_q[1] * mag1_q[2];

    mag3_q <= mag2_q;
    neg3_q <= neg2_q;
    shr3_q <= max2_q[31];
    shl3_q <= lead_zeros(max2_q) - 5'd1;
    ms3_q[0] <= sq2_q[1] + sq2_q[2];
    ms3_q[1] <= pm2_q[0];
    ms3_q[2] <= pm2_q[1];
    ms3_q[3] <= sq2_q[0] + sq2_q[2];
    ms3_q[4] <= pm2_q[2];
    ms3_q[5] <= sq2_q[0] + sq2_q[1];

    neg4_q <= neg3_q;
    ms4_q  <= ms3_q;
    for (int i = 0; i < 3; i++) begin
      u4_q[i] <= shr3_q ? (mag3_q[i] >> 1) : (mag3_q[i] << shl3_q);
    end

    neg5_q <= neg4_q;
    ms5_q  <= ms4_q;
    for (int k = 0; k < 6; k++) begin
      n5_q[k] <= 62'(u4_q[PAIR_I[k]][30:0] * u4_q[PAIR_J[k]][30:0]);
    end
  end

  assign item_valid_o = v_q[4];
  assign item_o.num   = n5_q;
  assign item_o.den   = (r2n[63:32] == '0) ? 32'd1 : r2n[63:32];
  assign item_o.msum  = ms5_q;
  assign item_o.neg   = neg5_q;

endmodule

@@ rtl/lpc_fifo.sv @@
// Short queue between front and back; memory with registered read.
// Depends on lpc_pkg. The back always drains, so a word is read as soon as one is held.
module lpc_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  lpc_pkg::lpc_item_t          wdata_i,
  output logic [lpc_pkg::FIFO_CW-1:0] cnt_o,
  output logic                        rd_valid_o,
  output lpc_pkg::lpc_item_t          rdata_o
);
  import lpc_pkg::*;

  lpc_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               rd;
  logic               rd_valid_q;
  lpc_item_t          rdata_q;

  assign rd = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd)   rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q      <= cnt_q + FIFO_CW'(wr_i) - FIFO_CW'(rd);
      rd_valid_q <= rd;
    end
  end

  // Storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i) mem[wr_ptr_q] <= wdata_i;
    if (rd)   rdata_q <= mem[rd_ptr_q];
  end

  assign cnt_o      = cnt_q;
  assign rd_valid_o = rd_valid_q;
  assign rdata_o    = rdata_q;

  // Front credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> cnt_q != FIFO_CW'(FIFO_DEPTH)) else $error("queue overflow");

endmodule

@@ rtl/lpc_back.sv @@
// Back of the covariance datapath: pipelined divides, range and angular terms, saturation.
// Depends on lpc_pkg. 17 divider stages of two quotient bits, then three stages to the output.
module lpc_back #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  lpc_pkg::lpc_item_t item_i,
  input  lpc_pkg::lpc_coef_t coef_i,
  output logic               res_valid_o,
  output lpc_pkg::lpc_out_t  result_o
);
  import lpc_pkg::*;

  localparam int unsigned SH         = 2 * COORD_FRAC_BITS;
  localparam int unsigned DIV_STAGES = 17;

  typedef struct packed {
    logic [5:0][31:0] rem;
    logic [5:0][33:0] quo;
    logic [5:0][33:0] low;
    logic [31:0]      den;
    logic [5:0][63:0] msum;
    logic [2:0]       neg;
  } div_t;

  div_t             dv [DIV_STAGES+1];
  logic [DIV_STAGES:0] dvv;

  // Divider entry
  always_comb begin
    dv[0].den  = item_i.den;
    dv[0].msum = item_i.msum;
    dv[0].neg  = item_i.neg;
    for (int k = 0; k < 6; k++) begin
      dv[0].rem[k] = {4'd0, item_i.num[k][61:34]};
      dv[0].quo[k] = '0;
      dv[0].low[k] = item_i.num[k][33:0];
    end
  end
  assign dvv[0] = item_valid_i;

  // Divider stages, two restoring steps each
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_t nx;
    always_comb begin
      logic [32:0] r;
      nx = dv[g];
      for (int k = 0; k < 6; k++) begin
        for (int b = 0; b < 2; b++) begin
          r = {nx.rem[k], nx.low[k][33]};
          nx.low[k] = {nx.low[k][32:0], 1'b0};
          if (r >= {1'b0, nx.den}) begin
            nx.rem[k] = 32'(r - {1'b0, nx.den});
            nx.quo[k] = {nx.quo[k][32:0], 1'b1};
          end else begin
            nx.rem[k] = r[31:0];
            nx.quo[k] = {nx.quo[k][32:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvv[g+1] <= 1'b0;
      else         dvv[g+1] <= dvv[g];
    end
    always_ff @(posedge clk_i) begin
      dv[g+1] <= nx;
    end
  end

  // Multiply stage: partial products of the angular term and the range term
  logic             vx_q, vy_q, vo_q;
  logic [5:0][63:0] pph_q, ppl_q;
  logic [5:0][64:0] btp_q;
  logic [2:0]       negx_q, negy_q;
  logic [5:0][32:0] qc;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      qc[k] = (dv[DIV_STAGES].quo[k] > 34'(ONE_Q32)) ? ONE_Q32
                                                     : dv[DIV_STAGES].quo[k][32:0];
    end
  end

  always_ff @(posedge clk_i) begin
    negx_q <= dv[DIV_STAGES].neg;
    for (int k = 0; k < 6; k++) begin
      pph_q[k] <= coef_i.s2 * dv[DIV_STAGES].msum[k][63:32];
      ppl_q[k] <= coef_i.s2 * dv[DIV_STAGES].msum[k][31:0];
      btp_q[k] <= {1'b0, coef_i.e2} * qc[k];
    end
  end

  // Assemble and scale the angular term, saturating
  logic [5:0][63:0] at_q;
  logic [5:0][32:0] bt_q;
  logic [5:0][95:0] pfull, psh;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pfull[k] = {pph_q[k], 32'd0} + {32'd0, ppl_q[k]};
      psh[k]   = pfull[k] >> SH;
    end
  end

  always_ff @(posedge clk_i) begin
    negy_q <= negx_q;
    for (int k = 0; k < 6; k++) begin
      at_q[k] <= (|psh[k][95:64]) ? '1 : psh[k][63:0];
      bt_q[k] <= btp_q[k][64:32];
    end
  end

  // Combine, sign and clamp
  logic [5:0][63:0] cov;
  logic             sat;
  always_comb begin
    logic [64:0] sum;
    logic [63:0] mg, btw;
    logic        ng, sgn;
    sat = 1'b0;
    for (int k = 0; k < 6; k++) begin
      sum = '0;
      sgn = 1'b0;
      btw = {31'd0, bt_q[k]};
      if (PAIR_I[k] == PAIR_J[k]) begin
        sum = {1'b0, at_q[k]} + {1'b0, btw};
        mg  = sum[64] ? '1 : sum[63:0];
        ng  = 1'b0;
      end else begin
        sgn = negy_q[PAIR_I[k]] ^ negy_q[PAIR_J[k]];
        if (btw >= at_q[k]) begin
          mg = btw - at_q[k];
          ng = sgn;
        end else begin
          mg = at_q[k] - btw;
          ng = !sgn;
        end
      end
      if (mg == '0) ng = 1'b0;
      if (ng) begin
        if (mg > NEG_MAG) begin
          mg  = NEG_MAG;
          sat = 1'b1;
        end
        cov[k] = ~mg + 64'd1;
      end else begin
        if (mg > POS_MAX) begin
          mg  = POS_MAX;
          sat = 1'b1;
        end
        cov[k] = mg;
      end
    end
  end

  lpc_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= 1'b0;
      vy_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vx_q <= dvv[DIV_STAGES];
      vy_q <= vx_q;
      vo_q <= vy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.cov_xx    <= cov[0];
    out_q.cov_xy    <= cov[1];
    out_q.cov_xz    <= cov[2];
    out_q.cov_yy    <= cov[3];
    out_q.cov_yz    <= cov[4];
    out_q.cov_zz    <= cov[5];
    out_q.saturated <= sat;
  end

  assign res_valid_o = vo_q;
  assign result_o    = out_q;

  // A clamp flag means some entry sits at a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && out_q.saturated |->
      out_q.cov_xx == POS_MAX || out_q.cov_yy == POS_MAX || out_q.cov_zz == POS_MAX ||
      out_q.cov_xy == POS_MAX || out_q.cov_xz == POS_MAX || out_q.cov_yz == POS_MAX ||
      out_q.cov_xy == NEG_MAG || out_q.cov_xz == NEG_MAG || out_q.cov_yz == NEG_MAG)
    else $error("saturated without clamped entry");

  // Diagonal entries are never negative
  a_diag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> !out_q.cov_xx[63] && !out_q.cov_yy[63] && !out_q.cov_zz[63])
    else $error("negative diagonal entry");

endmodule

@@ rtl/lidar_point_covariance.sv @@
// Top level of the LiDAR point noise covariance block.
// Depends on lpc_pkg, lpc_coef, lpc_front, lpc_fifo, lpc_back.
//
// Usage:
//  - Input: a point word (x, y, z, signed, COORD_FRAC_BITS fraction bits) is
//    taken at a clock edge with start high and busy low.
//  - Output: one result word per point, on result_o for one cycle with
//    res_valid_o high. The receiver cannot stall; words come in input order.
//  - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//    (0 range error, 1 beam angle error). The user must write only while
//    the block is idle; the block itself leaves this unchecked.
//  - Throughput: one point per cycle while busy is low. Stages: 5 front,
//    2 through the queue memory, 17 divider, 2 multiply, 1 output register.
//  - After reset and after every register write, the coefficient unit
//    recomputes sin^2 of the beam error on its single sequenced multiplier;
//    busy is high while it does so.
//  - Reset clears all control state; no point is in flight afterwards.
module lidar_point_covariance #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lpc_pkg::lpc_in_t               point_i,
  output logic                           res_valid_o,
  output lpc_pkg::lpc_out_t              result_o,
  input  logic                           cfg_we_i,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lpc_pkg::*;

  lpc_coef_t          coef;
  logic               front_ready;
  logic               accept;
  logic               item_valid;
  lpc_item_t          item;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic               q_valid;
  lpc_item_t          q_item;

  assign busy   = !front_ready;
  assign accept = start && front_ready;

  lpc_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  lpc_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .point_i      (point_i),
    .coef_busy_i  (coef.busy),
    .fifo_cnt_i   (fifo_cnt),
    .ready_o      (front_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lpc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (item_valid),
    .wdata_i    (item),
    .cnt_o      (fifo_cnt),
    .rd_valid_o (q_valid),
    .rdata_o    (q_item)
  );

  lpc_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .coef_i       (coef),
    .res_valid_o  (res_valid_o),
    .result_o     (result_o)
  );

endmodule

@@ tb/tb_lidar_point_covariance.sv @@
`timescale 1ns / 100ps
// Testbench for lidar_point_covariance: random and directed points, with the
// covariance of each point predicted here and checked word by word.
// Depends on lpc_pkg and the lidar_point_covariance RTL.
module tb_lidar_point_covariance;
  import lpc_pkg::*;

  localparam int FRAC = 16;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  lpc_in_t               point_i = '0;
  logic                  res_valid_o;
  lpc_out_t              result_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  lidar_point_covariance #(.COORD_FRAC_BITS(FRAC)) u_dut (.*);

  // Local copy of the two registers
  logic [15:0] range_err_q = RANGE_ERR_RST;
  logic [20:0] beam_err_q  = BEAM_ERR_RST;

  lpc_in_t  point_q[$];
  lpc_out_t cov_q[$];
  int       idle_pct = 0;
  int       n_err = 0;
  bit       took = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  // (a * m) >> sh, clamped to 64 bits
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] m, int sh);
    logic [127:0] prod;
    prod = ({64'b0, a} * {64'b0, m}) >> sh;
    return (prod[127:64] != 0) ? '1 : prod[63:0];
  endfunction

  // Covariance of one point under the current register values
  function automatic lpc_out_t cov_predict(lpc_in_t p);
    logic [31:0] v[3];
    logic [63:0] mag[3], sq[3], u[3], cv[6];
    logic [63:0] mx, r2n, d, beam, x, x2, t, s, s2, e2, q, bt, at, mg, msum;
    logic        neg[3];
    logic        ng, sgn, sat;
    int          a, b;
    lpc_out_t    r;
    v[0] = p.point_x; v[1] = p.point_y; v[2] = p.point_z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][31];
      mag[i] = {32'b0, neg[i] ? (~v[i] + 32'd1) : v[i]};
    end
    // zero z becomes 0.0001 m
    if (mag[2] == 0) begin
      mag[2] = ((64'd1 << FRAC) + 64'd5000) / 64'd10000;
      if (mag[2] == 0) mag[2] = 64'd1;
      neg[2] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      sq[i] = mag[i] * mag[i];
      u[i]  = mag[i];
    end
    // normalize so the largest magnitude lies in [2^30, 2^31)
    mx = u[0];
    if (u[1] > mx) mx = u[1];
    if (u[2] > mx) mx = u[2];
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1; u[0] = u[0] >> 1; u[1] = u[1] >> 1; u[2] = u[2] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1; u[0] = u[0] << 1; u[1] = u[1] << 1; u[2] = u[2] << 1;
    end
    r2n = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    d = r2n >> 32;
    if (d == 0) d = 64'd1;
    // truncated Taylor sine of the beam error
    beam = {43'b0, beam_err_q};
    if (beam > BEAM_MAX) beam = BEAM_MAX;
    x  = (beam * DEG2RAD_Q32) >> 16;
    x2 = (x * x) >> 32;
    t  = ONE_Q32;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd72;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd42;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd20;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd6;
    s  = (x * t) >> 32;
    s2 = (s * s) >> 32;
    e2 = range_err_q * range_err_q;
    sat = 1'b0;
    for (int k = 0; k < 6; k++) begin
      a = PAIR_I[k];
      b = PAIR_J[k];
      q = (u[a] * u[b]) / d;
      if (q > ONE_Q32) q = ONE_Q32;
      bt = (e2 * q) >> 32;
      if (a == b) begin
        msum = sq[(a + 1) % 3] + sq[(a + 2) % 3];
        at = mul_shift(s2, msum, 2 * FRAC);
        mg = (at > ~bt) ? '1 : at + bt;
        ng = 1'b0;
      end else begin
        sgn = neg[a] != neg[b];
        at = mul_shift(s2, mag[a] * mag[b], 2 * FRAC);
        if (bt >= at) begin
          mg = bt - at; ng = sgn;
        end else begin
          mg = at - bt; ng = !sgn;
        end
      end
      if (mg == 0) ng = 1'b0;
      if (ng) begin
        if (mg > NEG_MAG) begin
          mg = NEG_MAG; sat = 1'b1;
        end
        cv[k] = ~mg + 64'd1;
      end else begin
        if (mg > POS_MAX) begin
          mg = POS_MAX; sat = 1'b1;
        end
        cv[k] = mg;
      end
    end
    r.cov_xx = cv[0]; r.cov_xy = cv[1]; r.cov_xz = cv[2];
    r.cov_yy = cv[3]; r.cov_yz = cv[4]; r.cov_zz = cv[5];
    r.saturated = sat;
    return r;
  endfunction

  // Driver: hold a word until taken, else maybe load the next one
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took)) begin
      if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        point_i <= point_q[0];
        point_q.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Accept tracking and result checking
  always @(posedge clk_i) begin
    lpc_out_t xp;
    took = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        took = 1'b1;
        cov_q.insert(cov_q.size(), cov_predict(point_i));
      end
      if (res_valid_o) begin
        if (cov_q.size() == 0) begin
          $error("result word with no point pending");
          n_err++;
        end else begin
          xp = cov_q[0];
          cov_q.delete(0);
          if (result_o.cov_xx !== xp.cov_xx) begin
            $error("cov_xx exp %h got %h", xp.cov_xx, result_o.cov_xx); n_err++;
          end
          if (result_o.cov_xy !== xp.cov_xy) begin
            $error("cov_xy exp %h got %h", xp.cov_xy, result_o.cov_xy); n_err++;
          end
          if (result_o.cov_xz !== xp.cov_xz) begin
            $error("cov_xz exp %h got %h", xp.cov_xz, result_o.cov_xz); n_err++;
          end
          if (result_o.cov_yy !== xp.cov_yy) begin
            $error("cov_yy exp %h got %h", xp.cov_yy, result_o.cov_yy); n_err++;
          end
          if (result_o.cov_yz !== xp.cov_yz) begin
            $error("cov_yz exp %h got %h", xp.cov_yz, result_o.cov_yz); n_err++;
          end
          if (result_o.cov_zz !== xp.cov_zz) begin
            $error("cov_zz exp %h got %h", xp.cov_zz, result_o.cov_zz); n_err++;
          end
          if (result_o.saturated !== xp.saturated) begin
            $error("saturated exp %b got %b", xp.saturated, result_o.saturated); n_err++;
          end
        end
      end
    end
  end

  // Random coordinate: mostly moderate, some full range, some edge values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3, 4:    return $urandom;
      5:       return $signed($urandom_range(511)) - 256;
      default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic add_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    lpc_in_t p;
    p.point_x = px; p.point_y = py; p.point_z = pz;
    point_q.insert(point_q.size(), p);
  endtask

  // Wait until every word is taken and checked, plus pipeline drain
  task automatic drain();
    while (point_q.size() != 0 || start || cov_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic cfg_write(lpc_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RANGE_ERR) range_err_q = data[15:0];
    else beam_err_q = data;
  endtask

  task automatic run_phase(int idle, int n);
    idle_pct = idle;
    repeat (n) add_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // Stimulus
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // directed words at reset values
    add_point(0, 0, 0);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_point(32'h0001_0000, 0, 0);
    add_point(0, 32'hFFFF_0000, 0);
    add_point(1, -1, 1);
    add_point(32'h000A_0000, 32'hFFF6_0000, 32'h0002_0000);
    add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    add_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    drain();
    cfg_write(REG_RANGE_ERR, 21'd65535);
    cfg_write(REG_BEAM_ERR, BEAM_MAX);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(1, 1, 1);
    run_phase(0, 150);
    cfg_write(REG_RANGE_ERR, 21'd0);
    cfg_write(REG_BEAM_ERR, 21'd0);
    add_point(32'h0003_0000, 32'hFFFC_0000, 0);
    run_phase(85, 150);
    cfg_write(REG_BEAM_ERR, 21'h1F_FFFF);   // above the 30 degree cap
    cfg_write(REG_RANGE_ERR, 21'($urandom_range(65535)));
    run_phase(9, 150);
    cfg_write(REG_RANGE_ERR, 21'(RANGE_ERR_RST));
    cfg_write(REG_BEAM_ERR, BEAM_ERR_RST);
    run_phase(0, 150);
    cfg_write(REG_RANGE_ERR, 21'($urandom_range(65535)));
    cfg_write(REG_BEAM_ERR, 21'($urandom_range(BEAM_MAX)));
    run_phase(85, 150);
    cfg_write(REG_BEAM_ERR, 21'($urandom_range(21'h1F_FFFF)));
    run_phase($urandom_range(1) ? 9 : 50, 150);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
